// ----- src/qte_pkg.sv -----
// Shared constants and the arctangent table for the quaternion to Euler angle unit.
// Standalone package; used by quaternion_to_euler_angles_unit.
`default_nettype none

package qte_pkg;

   // Interface widths.
   localparam int QUAT_W     = 16;
   localparam int ANGLE_W    = 16;
   localparam int PITCH_W    = ANGLE_W - 1;
   localparam int REQ_DATA_W = 4 * QUAT_W;
   localparam int RSP_DATA_W = 48;

   // Angle arithmetic: the accumulator counts 1/32768 degree.
   localparam int CORDIC_STEPS   = 20;
   localparam int ACC_W          = 25;
   localparam int DEG90          = 90 * 32768;
   localparam int ROLL_YAW_LIMIT = 23040;
   localparam int PITCH_LIMIT    = 11520;

   // atan(2^-i) in units of 1/32768 degree.
   function automatic logic [21:0] atan_entry(input logic [4:0] idx);
      logic [21:0] val;
      unique case (idx)
         5'd0:  val = 22'd1474560;
         5'd1:  val = 22'd870484;
         5'd2:  val = 22'd459940;
         5'd3:  val = 22'd233473;
         5'd4:  val = 22'd117189;
         5'd5:  val = 22'd58652;
         5'd6:  val = 22'd29333;
         5'd7:  val = 22'd14667;
         5'd8:  val = 22'd7334;
         5'd9:  val = 22'd3667;
         5'd10: val = 22'd1833;
         5'd11: val = 22'd917;
         5'd12: val = 22'd458;
         5'd13: val = 22'd229;
         5'd14: val = 22'd115;
         5'd15: val = 22'd57;
         5'd16: val = 22'd29;
         5'd17: val = 22'd14;
         5'd18: val = 22'd7;
         5'd19: val = 22'd4;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ----- src/quaternion_to_euler_angles_unit.sv -----
// Converts one Q14 orientation quaternion into roll, pitch and yaw (degrees times 128).
// Depends on qte_pkg for constants and the arctangent table.
//
// One transaction is processed at a time: req_tready is high only while the unit is
// idle. A degenerate quaternion (all parts zero) goes straight to the output state and
// repeats the previous angles with the held flag set. Any other quaternion passes
// through the shared multiplier (10 products, one per cycle, then one product for the
// square root operand), the bit-pair square root and three passes of the shared CORDIC
// vectoring stage. Each pass has a load step, a normalizing shift, a pre-rotation step,
// 20 rotations and a finishing step. An angle whose two operands are both zero skips
// the shift, pre-rotation and rotations and goes from load to finishing. A finished
// result waits in the output state until the output register is free, and then
// sits in that register, so a new transaction may be accepted while the previous
// result is still pending on the rsp side.
`default_nettype none

module quaternion_to_euler_angles_unit
   import qte_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   // quat_x [15:0], quat_y [31:16], quat_z [47:32], quat_w [63:48]
   input  wire [REQ_DATA_W-1:0]   req_tdata,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // roll_deg [15:0], pitch_deg [30:16], yaw_deg [46:31], zero [47]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // held [0]
   output logic                   rsp_tuser
);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_PREP, S_MUL2, S_SQRT, S_LOAD, S_NORM, S_PRE, S_ITER, S_FIN, S_OUT
   } state_type;

   typedef enum logic [1:0] {JOB_ROLL, JOB_YAW, JOB_PITCH} job_type;

   // Product slots.
   localparam logic [3:0] P_II = 4'd0;
   localparam logic [3:0] P_JJ = 4'd1;
   localparam logic [3:0] P_KK = 4'd2;
   localparam logic [3:0] P_RR = 4'd3;
   localparam logic [3:0] P_RI = 4'd4;
   localparam logic [3:0] P_JK = 4'd5;
   localparam logic [3:0] P_RK = 4'd6;
   localparam logic [3:0] P_IJ = 4'd7;
   localparam logic [3:0] P_RJ = 4'd8;
   localparam logic [3:0] P_KI = 4'd9;
   localparam int         NUM_PROD = 10;

   state_type          state_ff;
   job_type            job_ff;
   logic signed [15:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [31:0] prod_ff [NUM_PROD];
   logic [3:0]         mul_idx_ff;
   logic [32:0]        n_ff, a_ff;
   logic               s_neg_ff;
   logic [63:0]        rad_ff, root_ff;
   logic [4:0]         sq_cnt_ff;
   logic signed [45:0] cx_ff, cy_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [4:0]         iter_ff;
   logic signed [15:0] last_roll_ff, last_yaw_ff;
   logic signed [14:0] last_pitch_ff;
   logic               held_ff;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic               rsp_held_ff;

   // Shared multiplier.
   logic signed [15:0] op1, op2;
   logic signed [34:0] mul_a, mul_b;
   logic signed [69:0] mul_p;

   always_comb begin
      unique case (mul_idx_ff)
         P_II:    begin op1 = qx_ff; op2 = qx_ff; end
         P_JJ:    begin op1 = qy_ff; op2 = qy_ff; end
         P_KK:    begin op1 = qz_ff; op2 = qz_ff; end
         P_RR:    begin op1 = qw_ff; op2 = qw_ff; end
         P_RI:    begin op1 = qw_ff; op2 = qx_ff; end
         P_JK:    begin op1 = qy_ff; op2 = qz_ff; end
         P_RK:    begin op1 = qw_ff; op2 = qz_ff; end
         P_IJ:    begin op1 = qx_ff; op2 = qy_ff; end
         P_RJ:    begin op1 = qw_ff; op2 = qy_ff; end
         P_KI:    begin op1 = qz_ff; op2 = qx_ff; end
         default: begin op1 = '0; op2 = '0; end
      endcase
      if (state_ff == S_MUL2) begin
         mul_a = $signed({2'b00, n_ff - a_ff});
         mul_b = $signed({1'b0, {1'b0, n_ff} + {1'b0, a_ff}});
      end else begin
         mul_a = 35'(op1);
         mul_b = 35'(op2);
      end
      mul_p = mul_a * mul_b;
   end

   // Squared norm, pitch numerator and its clamp.
   logic [32:0]        n2;
   logic signed [33:0] s_val;
   logic [33:0]        s_abs;
   logic [32:0]        a_cl;

   always_comb begin
      n2 = {1'b0, prod_ff[P_II]} + {1'b0, prod_ff[P_JJ]}
         + {1'b0, prod_ff[P_KK]} + {1'b0, prod_ff[P_RR]};
      s_val = (34'(prod_ff[P_RJ]) - 34'(prod_ff[P_KI])) <<< 1;
      s_abs = s_val[33] ? 34'(-s_val) : 34'(s_val);
      a_cl  = (s_abs[32:0] > n2) ? n2 : s_abs[32:0];
   end

   // Square root step.
   logic [63:0] sq_bit, sq_trial;

   always_comb begin
      sq_bit   = 64'd1 << {sq_cnt_ff, 1'b0};
      sq_trial = root_ff + sq_bit;
   end

   // CORDIC operand selection for the current angle.
   logic signed [33:0] ld_y, ld_x;

   always_comb begin
      unique case (job_ff)
         JOB_ROLL: begin
            ld_y = (34'(prod_ff[P_RI]) + 34'(prod_ff[P_JK])) <<< 1;
            ld_x = 34'(prod_ff[P_RR]) + 34'(prod_ff[P_KK])
                 - 34'(prod_ff[P_II]) - 34'(prod_ff[P_JJ]);
         end
         JOB_YAW: begin
            ld_y = (34'(prod_ff[P_RK]) + 34'(prod_ff[P_IJ])) <<< 1;
            ld_x = 34'(prod_ff[P_RR]) + 34'(prod_ff[P_II])
                 - 34'(prod_ff[P_JJ]) - 34'(prod_ff[P_KK]);
         end
         default: begin
            ld_y = $signed({1'b0, a_ff});
            ld_x = $signed({1'b0, root_ff[32:0]});
         end
      endcase
   end

   // Normalizing magnitude and one rotation step.
   logic [45:0]        mag_x, mag_y, mag_m;
   logic signed [45:0] dx, dy;
   logic signed [ACC_W-1:0] atan_val;

   always_comb begin
      mag_x    = cx_ff[45] ? 46'(-cx_ff) : 46'(cx_ff);
      mag_y    = cy_ff[45] ? 46'(-cy_ff) : 46'(cy_ff);
      mag_m    = (mag_x > mag_y) ? mag_x : mag_y;
      dx       = cy_ff >>> iter_ff;
      dy       = cx_ff >>> iter_ff;
      atan_val = $signed({3'b000, atan_entry(iter_ff)});
   end

   // Rounding and clamping of the finished angle.
   logic signed [ACC_W-1:0] acc_sel, acc_rnd, lim, ang;

   always_comb begin
      acc_sel = (job_ff == JOB_PITCH && s_neg_ff) ? -acc_ff : acc_ff;
      acc_rnd = (acc_sel + ACC_W'(128)) >>> 8;
      lim     = (job_ff == JOB_PITCH) ? ACC_W'(PITCH_LIMIT) : ACC_W'(ROLL_YAW_LIMIT);
      priority if (acc_rnd > lim)  ang = lim;
      else if (acc_rnd < -lim)     ang = -lim;
      else                         ang = acc_rnd;
   end

   // The output register takes a finished result once it is empty or being drained.
   logic out_load;

   always_comb begin
      out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   end

   // Sequencer, datapath registers and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         job_ff        <= JOB_ROLL;
         mul_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         last_roll_ff  <= '0;
         last_pitch_ff <= '0;
         last_yaw_ff   <= '0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  qx_ff      <= $signed(req_tdata[15:0]);
                  qy_ff      <= $signed(req_tdata[31:16]);
                  qz_ff      <= $signed(req_tdata[47:32]);
                  qw_ff      <= $signed(req_tdata[63:48]);
                  mul_idx_ff <= P_II;
                  held_ff    <= (req_tdata == '0);
                  state_ff   <= (req_tdata == '0) ? S_OUT : S_MUL;
               end
            end
            S_MUL: begin
               prod_ff[mul_idx_ff] <= mul_p[31:0];
               mul_idx_ff          <= mul_idx_ff + 4'd1;
               if (mul_idx_ff == P_KI) begin
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               s_neg_ff <= s_val[33];
               if (n2[32]) begin
                  n_ff <= n2 >> 1;
                  a_ff <= a_cl >> 1;
               end else begin
                  n_ff <= n2;
                  a_ff <= a_cl;
               end
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               rad_ff    <= mul_p[63:0];
               root_ff   <= '0;
               sq_cnt_ff <= 5'd31;
               state_ff  <= S_SQRT;
            end
            S_SQRT: begin
               if (rad_ff >= sq_trial) begin
                  rad_ff  <= rad_ff - sq_trial;
                  root_ff <= (root_ff >> 1) + sq_bit;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               sq_cnt_ff <= sq_cnt_ff - 5'd1;
               if (sq_cnt_ff == 5'd0) begin
                  job_ff   <= JOB_ROLL;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               cx_ff  <= 46'(ld_x);
               cy_ff  <= 46'(ld_y);
               acc_ff <= '0;
               state_ff <= (ld_x == '0 && ld_y == '0) ? S_FIN : S_NORM;
            end
            S_NORM: begin
               // Scale up until the larger operand reaches 2^40.
               priority if (mag_m < (46'd1 << 32)) begin
                  cx_ff <= cx_ff <<< 8;
                  cy_ff <= cy_ff <<< 8;
               end else if (mag_m < (46'd1 << 40)) begin
                  cx_ff <= cx_ff <<< 1;
                  cy_ff <= cy_ff <<< 1;
               end else begin
                  state_ff <= S_PRE;
               end
            end
            S_PRE: begin
               // Quadrant pre-rotation by plus or minus 90 degrees when x is negative.
               if (cx_ff[45]) begin
                  if (!cy_ff[45]) begin
                     cx_ff  <= cy_ff;
                     cy_ff  <= -cx_ff;
                     acc_ff <= ACC_W'(DEG90);
                  end else begin
                     cx_ff  <= -cy_ff;
                     cy_ff  <= cx_ff;
                     acc_ff <= -ACC_W'(DEG90);
                  end
               end
               iter_ff  <= '0;
               state_ff <= S_ITER;
            end
            S_ITER: begin
               if (!cy_ff[45]) begin
                  cx_ff  <= cx_ff + dx;
                  cy_ff  <= cy_ff - dy;
                  acc_ff <= acc_ff + atan_val;
               end else begin
                  cx_ff  <= cx_ff - dx;
                  cy_ff  <= cy_ff + dy;
                  acc_ff <= acc_ff - atan_val;
               end
               iter_ff <= iter_ff + 5'd1;
               if (iter_ff == 5'(CORDIC_STEPS - 1)) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               unique case (job_ff)
                  JOB_ROLL: begin
                     last_roll_ff <= ang[15:0];
                     job_ff       <= JOB_YAW;
                     state_ff     <= S_LOAD;
                  end
                  JOB_YAW: begin
                     last_yaw_ff <= ang[15:0];
                     job_ff      <= JOB_PITCH;
                     state_ff    <= S_LOAD;
                  end
                  default: begin
                     last_pitch_ff <= ang[14:0];
                     state_ff      <= S_OUT;
                  end
               endcase
            end
            S_OUT: begin
               if (out_load) begin
                  rsp_data_ff  <= {1'b0, last_yaw_ff, last_pitch_ff, last_roll_ff};
                  rsp_held_ff  <= held_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_held_ff;

`ifndef SYNTHESIS
   // Pitch stays within plus or minus 90 degrees.
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[30:16]) <= 15'sd11520 &&
                      $signed(rsp_tdata[30:16]) >= -15'sd11520))
      else $error("pitch out of range");

   // Roll and yaw stay within plus or minus 180 degrees.
   a_roll_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd23040 &&
                      $signed(rsp_tdata[15:0]) >= -16'sd23040 &&
                      $signed(rsp_tdata[46:31]) <= 16'sd23040 &&
                      $signed(rsp_tdata[46:31]) >= -16'sd23040))
      else $error("roll or yaw out of range");

   // A degenerate quaternion skips all arithmetic.
   a_held_shortcut: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata == '0) |=> (state_ff == S_OUT && held_ff))
      else $error("degenerate quaternion not short-cut");

   // The rotation counter never runs past the table.
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ITER) |-> (iter_ff < 5'(CORDIC_STEPS)))
      else $error("CORDIC step counter overrun");
`endif

endmodule

`default_nettype wire
